@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held
`define RPC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also holds across reset
`define RPC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/rpc_pkg.sv @@
// ---------------------------------------------------------------------------
// Rectangular/polar converter package
// Constants, stage words and helper functions for the CORDIC datapath.
// ---------------------------------------------------------------------------
package rpc_pkg;

    // Port widths (tdata padded to whole bytes)
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 72;

    // Command codes
    localparam logic [1:0] CMD_RECT  = 2'd0;
    localparam logic [1:0] CMD_POLAR = 2'd1;

    // Datapath: 14 fraction bits on x/y, angles in 2^-24 rad
    localparam int DP_W      = 34;
    localparam int ANG_W     = 28;
    localparam int FRAC_BITS = 14;
    localparam int TABLE_LEN = 24;

    localparam logic signed [ANG_W-1:0] PI24        = 28'sd52707179;
    localparam logic signed [ANG_W-1:0] HALFPI24    = 28'sd26353589;
    localparam logic signed [ANG_W-1:0] ANGLE_LIMIT = 28'sd25736;

    // deg/128 -> 2^-24 rad, scaled by 2^16
    localparam logic signed [28:0] DEG128_TO_RAD = 29'sd149922641;
    // 1/K in Q30
    localparam logic signed [30:0] INV_GAIN_Q30  = 31'sd652032874;

    localparam logic signed [17:0] TURN_DEG128      = 18'sd46080;
    localparam logic signed [17:0] HALF_TURN_DEG128 = 18'sd23040;

    // Word handed into and out of the CORDIC iteration stages
    typedef struct packed {
        logic                    polar;
        logic                    err;
        logic                    zero;
        logic signed [16:0]      xo;
        logic signed [16:0]      yo;
        logic [15:0]             mo;
        logic signed [15:0]      ao;
        logic signed [DP_W-1:0]  x;
        logic signed [DP_W-1:0]  y;
        logic signed [ANG_W-1:0] z;
    } cordic_word_t;

    // Arctangent table, 2^-24 rad, rounded to nearest
    function automatic logic signed [ANG_W-1:0] atan_lut(input logic [4:0] idx);
        logic signed [ANG_W-1:0] val;
        unique case (idx)
            5'd0:    val = 28'sd13176795;
            5'd1:    val = 28'sd7778716;
            5'd2:    val = 28'sd4110060;
            5'd3:    val = 28'sd2086331;
            5'd4:    val = 28'sd1047214;
            5'd5:    val = 28'sd524117;
            5'd6:    val = 28'sd262123;
            5'd7:    val = 28'sd131069;
            5'd8:    val = 28'sd65536;
            5'd9:    val = 28'sd32768;
            5'd10:   val = 28'sd16384;
            5'd11:   val = 28'sd8192;
            5'd12:   val = 28'sd4096;
            5'd13:   val = 28'sd2048;
            5'd14:   val = 28'sd1024;
            5'd15:   val = 28'sd512;
            5'd16:   val = 28'sd256;
            5'd17:   val = 28'sd128;
            5'd18:   val = 28'sd64;
            5'd19:   val = 28'sd32;
            5'd20:   val = 28'sd16;
            5'd21:   val = 28'sd8;
            5'd22:   val = 28'sd4;
            5'd23:   val = 28'sd2;
            default: val = '0;
        endcase
        return val;
    endfunction

    // Signed saturation; callers truncate to their own width
    function automatic logic signed [64:0] sat(input logic signed [64:0] v,
                                               input logic signed [64:0] lo,
                                               input logic signed [64:0] hi);
        logic signed [64:0] r;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

@@ hdl/rpc_cordic_pipe.sv @@
// ---------------------------------------------------------------------------
// CORDIC iteration pipeline
// One register stage per micro-rotation; vectoring or rotation per word.
// ---------------------------------------------------------------------------
module rpc_cordic_pipe #(
    parameter int STAGES = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  rpc_pkg::cordic_word_t in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rpc_pkg::cordic_word_t out_word
);
    import rpc_pkg::*;

    cordic_word_t      word_reg  [STAGES];
    cordic_word_t      word_next [STAGES];
    cordic_word_t      src_word  [STAGES];
    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] src_valid;
    logic [STAGES:0]   rdy;

    // Ready ripples back; a stage moves when empty or when its successor moves
    always_comb begin
        rdy[STAGES] = out_ready;
        for (int k = STAGES - 1; k >= 0; k--) begin
            rdy[k] = !valid_reg[k] || rdy[k+1];
        end
    end

    assign src_valid = {valid_reg[STAGES-2:0], in_valid};
    assign src_word[0] = in_word;

    genvar g;
    generate
        for (g = 0; g < STAGES; g++) begin : g_stage
            logic                    rot_neg;
            logic signed [DP_W-1:0]  xs, ys, dx, dy;
            logic signed [ANG_W-1:0] zs, da;

            if (g > 0) begin : g_src
                assign src_word[g] = word_reg[g-1];
            end

            // One micro-rotation: fixed shift of g, table angle g
            always_comb begin
                xs = src_word[g].x;
                ys = src_word[g].y;
                zs = src_word[g].z;
                dx = ys >>> g;
                dy = xs >>> g;
                da = atan_lut(5'(g));
                // vectoring drives y to zero, rotation drives z to zero
                rot_neg = src_word[g].polar ? (zs >= 0) : (ys < 0);
                word_next[g] = src_word[g];
                if (rot_neg) begin
                    word_next[g].x = xs - dx;
                    word_next[g].y = ys + dy;
                    word_next[g].z = zs - da;
                end else begin
                    word_next[g].x = xs + dx;
                    word_next[g].y = ys - dy;
                    word_next[g].z = zs + da;
                end
            end
        end
    endgenerate

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < STAGES; k++) begin
                if (rdy[k]) begin
                    valid_reg[k] <= src_valid[k];
                end
            end
        end
    end

    // Stage payload
    always_ff @(posedge aclk) begin
        for (int k = 0; k < STAGES; k++) begin
            if (rdy[k]) begin
                word_reg[k] <= word_next[k];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[STAGES-1];
    assign out_word  = word_reg[STAGES-1];

endmodule

@@ hdl/rect_polar_converter_top.sv @@
// ---------------------------------------------------------------------------
// Rectangular/polar converter
// Pipelined CORDIC converting x/y to magnitude/angle and back.
// ---------------------------------------------------------------------------
// Input words arrive on the s_ channel: s_tuser carries the command
// (0 rectangular, 1 polar, others rejected), s_tdata the two operands.
// Rectangular words return x and y saturated plus magnitude and atan2 angle
// (Q3.13 rad); polar words (magnitude, angle in 1/128 degree) return x, y,
// the magnitude saturated and the wrapped angle in radians. A rejected
// command returns all zero fields with m_tuser set.
// The pipeline has four set-up stages, one stage per CORDIC iteration, two
// stages for the gain multiply and the output register. It takes one word
// per cycle while the receiver keeps up; every stage has its own valid bit
// and holds while the stage after it is full and cannot move on.
// When the receiver stalls, the result waits in the output register and
// empty stages further back still take new words, so s_tready drops only
// once the whole pipeline is full. Reset empties the pipeline; there is no
// other state.
// ---------------------------------------------------------------------------
module rect_polar_converter_top #(
    parameter int CORDIC_STAGES = 16,
    parameter int COORD_WIDTH   = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [16:0] first_value, [33:17] second_value
    input  logic [rpc_pkg::IN_DATA_W-1:0]  s_tdata,
    // [1:0] command
    input  logic [1:0]                     s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [16:0] x_coord, [33:17] y_coord, [49:34] magnitude, [65:50] angle_rad
    output logic [rpc_pkg::OUT_DATA_W-1:0] m_tdata,
    // [0] form_error
    output logic [0:0]                     m_tuser
);
    import rpc_pkg::*;

    localparam int NS = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;
    localparam longint unsigned LIM_RAW = (64'd1 << COORD_WIDTH) - 64'd1;
    localparam logic signed [17:0] LIM = (LIM_RAW > 64'd65535) ? 18'sd65535
                                                               : 18'(LIM_RAW);

    typedef struct packed {
        logic               polar;
        logic               err;
        logic signed [16:0] a;
        logic signed [16:0] b;
        logic signed [15:0] d;
        logic signed [16:0] xo;
        logic signed [16:0] yo;
    } pre1_t;

    typedef struct packed {
        pre1_t              p;
        logic signed [44:0] prod;
    } pre2_t;

    typedef struct packed {
        logic                    polar;
        logic                    err;
        logic                    zero;
        logic signed [16:0]      a;
        logic signed [16:0]      b;
        logic signed [16:0]      xo;
        logic signed [16:0]      yo;
        logic [15:0]             mo;
        logic signed [15:0]      ao;
        logic signed [ANG_W-1:0] z;
    } pre3_t;

    typedef struct packed {
        logic               polar;
        logic               err;
        logic               zero;
        logic signed [16:0] xo;
        logic signed [16:0] yo;
        logic [15:0]        mo;
        logic signed [15:0] ao;
        logic signed [47:0] phx;
        logic signed [48:0] plx;
        logic signed [47:0] phy;
        logic signed [48:0] ply;
    } mul1_t;

    typedef struct packed {
        logic               polar;
        logic               err;
        logic               zero;
        logic signed [16:0] xo;
        logic signed [16:0] yo;
        logic [15:0]        mo;
        logic signed [15:0] ao;
        logic signed [64:0] sx;
        logic signed [64:0] sy;
    } mul2_t;

    pre1_t        p1_reg, p1_next;
    pre2_t        p2_reg, p2_next;
    pre3_t        p3_reg, p3_next;
    cordic_word_t p4_reg, p4_next;
    mul1_t        m1_reg, m1_next;
    mul2_t        m2_reg, m2_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic         out_err_reg, out_err_next;

    logic p1_valid_reg, p2_valid_reg, p3_valid_reg, p4_valid_reg;
    logic m1_valid_reg, m2_valid_reg, out_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy_m1, rdy_m2, rdy_o;

    logic         cw_in_ready, cw_out_valid;
    cordic_word_t cw_out;

    // Back-pressure chain
    assign rdy_o  = !out_valid_reg || m_tready;
    assign rdy_m2 = !m2_valid_reg || rdy_o;
    assign rdy_m1 = !m1_valid_reg || rdy_m2;
    assign rdy4   = !p4_valid_reg || cw_in_ready;
    assign rdy3   = !p3_valid_reg || rdy4;
    assign rdy2   = !p2_valid_reg || rdy3;
    assign rdy1   = !p1_valid_reg || rdy2;
    assign s_tready = rdy1;

    // Stage 1: decode, saturate x/y, wrap the degree angle into (-180, 180]
    always_comb begin
        logic signed [17:0] b_ext;
        logic signed [17:0] d_ext;
        p1_next.polar = (s_tuser == CMD_POLAR);
        p1_next.err   = (s_tuser != CMD_POLAR) && (s_tuser != CMD_RECT);
        p1_next.a     = s_tdata[16:0];
        p1_next.b     = s_tdata[33:17];
        b_ext         = 18'(p1_next.b);
        if (b_ext > HALF_TURN_DEG128) begin
            d_ext = b_ext - TURN_DEG128;
        end else if (b_ext <= -HALF_TURN_DEG128) begin
            d_ext = b_ext + TURN_DEG128;
        end else begin
            d_ext = b_ext;
        end
        p1_next.d  = d_ext[15:0];
        p1_next.xo = 17'(sat(65'(p1_next.a), 65'(-LIM), 65'(LIM)));
        p1_next.yo = 17'(sat(65'(p1_next.b), 65'(-LIM), 65'(LIM)));
    end

    // Stage 2: degrees to radians product
    always_comb begin
        p2_next.p    = p1_reg;
        p2_next.prod = 45'(p1_reg.d) * 45'(DEG128_TO_RAD);
    end

    // Stage 3: round to 2^-24 rad, polar angle and magnitude fields
    always_comb begin
        logic signed [44:0]      z_full;
        logic signed [ANG_W-1:0] a_sum;
        z_full        = (p2_reg.prod + (45'sd1 <<< 15)) >>> 16;
        p3_next.polar = p2_reg.p.polar;
        p3_next.err   = p2_reg.p.err;
        p3_next.zero  = (p2_reg.p.a == '0) && (p2_reg.p.b == '0);
        p3_next.a     = p2_reg.p.a;
        p3_next.b     = p2_reg.p.b;
        p3_next.xo    = p2_reg.p.xo;
        p3_next.yo    = p2_reg.p.yo;
        p3_next.z     = z_full[ANG_W-1:0];
        a_sum         = (p3_next.z + 28'sd1024) >>> 11;
        p3_next.ao    = 16'(sat(65'(a_sum), 65'(-ANGLE_LIMIT), 65'(ANGLE_LIMIT)));
        p3_next.mo    = 16'(sat(65'(p2_reg.p.a), 65'sd0, 65'(LIM)));
    end

    // Stage 4: CORDIC start point, half-plane and quadrant folding
    always_comb begin
        logic signed [DP_W-1:0] xa;
        logic signed [DP_W-1:0] yb;
        xa            = DP_W'(p3_reg.a) <<< FRAC_BITS;
        yb            = DP_W'(p3_reg.b) <<< FRAC_BITS;
        p4_next.polar = p3_reg.polar;
        p4_next.err   = p3_reg.err;
        p4_next.zero  = p3_reg.zero;
        p4_next.xo    = p3_reg.xo;
        p4_next.yo    = p3_reg.yo;
        p4_next.mo    = p3_reg.mo;
        p4_next.ao    = p3_reg.ao;
        if (p3_reg.polar) begin
            p4_next.y = '0;
            if (p3_reg.z > HALFPI24) begin
                p4_next.x = -xa;
                p4_next.z = p3_reg.z - PI24;
            end else if (p3_reg.z < -HALFPI24) begin
                p4_next.x = -xa;
                p4_next.z = p3_reg.z + PI24;
            end else begin
                p4_next.x = xa;
                p4_next.z = p3_reg.z;
            end
        end else if (p3_reg.a < 0) begin
            // left half-plane: rotate by pi first
            p4_next.x = -xa;
            p4_next.y = -yb;
            p4_next.z = (p3_reg.b >= 0) ? PI24 : -PI24;
        end else begin
            p4_next.x = xa;
            p4_next.y = yb;
            p4_next.z = '0;
        end
    end

    rpc_cordic_pipe #(
        .STAGES    (NS)
    ) u_cordic (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (p4_valid_reg),
        .in_ready  (cw_in_ready),
        .in_word   (p4_reg),
        .out_valid (cw_out_valid),
        .out_ready (rdy_m1),
        .out_word  (cw_out)
    );

    // Gain compensation, partial products (34 bits split at bit 17)
    always_comb begin
        logic signed [ANG_W-1:0] a_sum;
        logic signed [15:0]      ao_rect;
        a_sum         = (cw_out.z + 28'sd1024) >>> 11;
        ao_rect       = 16'(sat(65'(a_sum), 65'(-ANGLE_LIMIT), 65'(ANGLE_LIMIT)));
        m1_next.polar = cw_out.polar;
        m1_next.err   = cw_out.err;
        m1_next.zero  = cw_out.zero;
        m1_next.xo    = cw_out.xo;
        m1_next.yo    = cw_out.yo;
        m1_next.mo    = cw_out.mo;
        if (cw_out.polar) begin
            m1_next.ao = cw_out.ao;
        end else if (cw_out.zero) begin
            m1_next.ao = '0;
        end else begin
            m1_next.ao = ao_rect;
        end
        m1_next.phx = 48'($signed(cw_out.x[DP_W-1:17])) * 48'(INV_GAIN_Q30);
        m1_next.plx = 49'($signed({1'b0, cw_out.x[16:0]})) * 49'(INV_GAIN_Q30);
        m1_next.phy = 48'($signed(cw_out.y[DP_W-1:17])) * 48'(INV_GAIN_Q30);
        m1_next.ply = 49'($signed({1'b0, cw_out.y[16:0]})) * 49'(INV_GAIN_Q30);
    end

    // Gain compensation, recombine partial products
    always_comb begin
        m2_next.polar = m1_reg.polar;
        m2_next.err   = m1_reg.err;
        m2_next.zero  = m1_reg.zero;
        m2_next.xo    = m1_reg.xo;
        m2_next.yo    = m1_reg.yo;
        m2_next.mo    = m1_reg.mo;
        m2_next.ao    = m1_reg.ao;
        m2_next.sx    = (65'(m1_reg.phx) <<< 17) + 65'(m1_reg.plx);
        m2_next.sy    = (65'(m1_reg.phy) <<< 17) + 65'(m1_reg.ply);
    end

    // Output: round, saturate, select by command
    always_comb begin
        logic signed [64:0] rx;
        logic signed [64:0] ry;
        logic signed [16:0] x_out;
        logic signed [16:0] y_out;
        logic [15:0]        mag_out;
        logic signed [15:0] ang_out;
        rx = (m2_reg.sx + (65'sd1 <<< (30 + FRAC_BITS - 1))) >>> (30 + FRAC_BITS);
        ry = (m2_reg.sy + (65'sd1 <<< (30 + FRAC_BITS - 1))) >>> (30 + FRAC_BITS);
        if (m2_reg.err) begin
            x_out   = '0;
            y_out   = '0;
            mag_out = '0;
            ang_out = '0;
        end else if (m2_reg.polar) begin
            x_out   = 17'(sat(rx, 65'(-LIM), 65'(LIM)));
            y_out   = 17'(sat(ry, 65'(-LIM), 65'(LIM)));
            mag_out = m2_reg.mo;
            ang_out = m2_reg.ao;
        end else begin
            x_out   = m2_reg.xo;
            y_out   = m2_reg.yo;
            mag_out = m2_reg.zero ? 16'd0 : 16'(sat(rx, 65'sd0, 65'(LIM)));
            ang_out = m2_reg.ao;
        end
        out_data_next = {6'd0, ang_out, mag_out, y_out, x_out};
        out_err_next  = m2_reg.err;
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p4_valid_reg  <= 1'b0;
            m1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                p1_valid_reg <= s_tvalid;
            end
            if (rdy2) begin
                p2_valid_reg <= p1_valid_reg;
            end
            if (rdy3) begin
                p3_valid_reg <= p2_valid_reg;
            end
            if (rdy4) begin
                p4_valid_reg <= p3_valid_reg;
            end
            if (rdy_m1) begin
                m1_valid_reg <= cw_out_valid;
            end
            if (rdy_m2) begin
                m2_valid_reg <= m1_valid_reg;
            end
            if (rdy_o) begin
                out_valid_reg <= m2_valid_reg;
            end
        end
    end

    // Stage payload
    always_ff @(posedge aclk) begin
        if (rdy1) begin
            p1_reg <= p1_next;
        end
        if (rdy2) begin
            p2_reg <= p2_next;
        end
        if (rdy3) begin
            p3_reg <= p3_next;
        end
        if (rdy4) begin
            p4_reg <= p4_next;
        end
        if (rdy_m1) begin
            m1_reg <= m1_next;
        end
        if (rdy_m2) begin
            m2_reg <= m2_next;
        end
        if (rdy_o) begin
            out_data_reg <= out_data_next;
            out_err_reg  <= out_err_next;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_err_reg;

endmodule

@@ hdl/rpc_checker.sv @@
// ---------------------------------------------------------------------------
// Converter port checker
// Watches the result channel of the converter over time.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rpc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rpc_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic [0:0]                     m_tuser
);
    import rpc_pkg::*;

    // Stalled word stays offered and unchanged
    `RPC_ASSERT(a_stall_valid, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result word dropped while stalled")
    `RPC_ASSERT(a_stall_data, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")

    // Rejected command gives all-zero fields
    `RPC_ASSERT(a_err_zero, aclk, aresetn, m_tvalid && m_tuser[0] |-> (m_tdata == '0), "error word carries non-zero fields")

    // Angle never beyond plus or minus pi
    `RPC_ASSERT(a_angle_range, aclk, aresetn, m_tvalid |-> ($signed(m_tdata[65:50]) <= 16'sd25736) && ($signed(m_tdata[65:50]) >= -16'sd25736), "angle outside plus or minus pi")

    // Reset empties the pipeline
    `RPC_ASSERT_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule

bind rect_polar_converter_top rpc_checker u_rpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Rectangular/polar converter testbench
// Drives command words into the converter and predicts every result with a
// behavioural CORDIC of its own. Results are compared field by field, in
// order. Directed corner cases come first, then random traffic under varying
// idle patterns, then a long receiver hold-off that fills the pipeline.
// ---------------------------------------------------------------------------
module tb;

    localparam int  NUM_ITER     = 16;
    localparam int  FRAC_SHIFT   = 14;
    localparam longint COORD_LIM = 65535;
    localparam longint ANG_LIM   = 25736;
    localparam longint PI_Z      = 52707179;
    localparam longint HALF_PI_Z = 26353589;
    localparam longint GAIN_INV  = 652032874;
    localparam longint DEG_SCALE = 149922641;
    localparam int  TURN         = 46080;
    localparam int  HALF_TURN    = 23040;
    localparam int  STALL_LIMIT  = 2000;
    localparam int  HOLD_CYCLES  = 400;
    localparam int  TAIL_CYCLES  = 40;

    // Command codes beyond the two valid forms
    localparam logic [1:0] CMD_BAD_A = 2'd2;
    localparam logic [1:0] CMD_BAD_B = 2'd3;

    typedef struct packed {
        logic [16:0] x_coord;
        logic [16:0] y_coord;
        logic [15:0] magnitude;
        logic [15:0] angle_rad;
        logic        form_error;
    } conv_result_t;

    // Arctangent of 2^-i in 2^-24 rad
    localparam longint ATAN_Z [NUM_ITER] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512
    };

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [rpc_pkg::IN_DATA_W-1:0]  s_tdata;
    logic [1:0]                     s_tuser;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [rpc_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [0:0]                     m_tuser;

    conv_result_t pending_results [$];
    int error_count = 0;
    int gap_pct     = 0;    // sender idle chance, percent
    int stall_pct   = 0;    // receiver idle chance, percent
    int hold_req    = 0;    // bumped to request a long receiver hold-off

    rect_polar_converter_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic longint limit_to(input longint v, input longint lo,
                                        input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Round half up after an arithmetic right shift
    function automatic longint round_shr(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // Behavioural converter: one input word to its expected result
    function automatic conv_result_t convert_word(input logic [1:0] cmd,
                                                  input longint a, input longint b);
        conv_result_t r;
        longint xw, yw, zw, dx, dy, deg, v;
        r = '0;
        if (cmd == rpc_pkg::CMD_RECT) begin
            v = limit_to(a, -COORD_LIM, COORD_LIM);
            r.x_coord = v[16:0];
            v = limit_to(b, -COORD_LIM, COORD_LIM);
            r.y_coord = v[16:0];
            if (a != 0 || b != 0) begin
                xw = a * (longint'(1) <<< FRAC_SHIFT);
                yw = b * (longint'(1) <<< FRAC_SHIFT);
                zw = 0;
                // left half-plane: fold over and start from +/- pi
                if (a < 0) begin
                    xw = -xw;
                    yw = -yw;
                    zw = (b >= 0) ? PI_Z : -PI_Z;
                end
                for (int i = 0; i < NUM_ITER; i++) begin
                    dx = yw >>> i;
                    dy = xw >>> i;
                    if (yw < 0) begin
                        xw -= dx; yw += dy; zw -= ATAN_Z[i];
                    end else begin
                        xw += dx; yw -= dy; zw += ATAN_Z[i];
                    end
                end
                v = limit_to(round_shr(xw * GAIN_INV, 30 + FRAC_SHIFT), 0, COORD_LIM);
                r.magnitude = v[15:0];
                v = limit_to(round_shr(zw, 11), -ANG_LIM, ANG_LIM);
                r.angle_rad = v[15:0];
            end
        end else if (cmd == rpc_pkg::CMD_POLAR) begin
            // wrap by whole turns into (-180, 180]
            deg = b;
            while (deg > HALF_TURN) deg -= TURN;
            while (deg <= -HALF_TURN) deg += TURN;
            zw = round_shr(deg * DEG_SCALE, 16);
            v = limit_to(round_shr(zw, 11), -ANG_LIM, ANG_LIM);
            r.angle_rad = v[15:0];
            v = limit_to(a, 0, COORD_LIM);
            r.magnitude = v[15:0];
            xw = a * (longint'(1) <<< FRAC_SHIFT);
            yw = 0;
            if (zw > HALF_PI_Z) begin
                xw = -xw;
                zw -= PI_Z;
            end else if (zw < -HALF_PI_Z) begin
                xw = -xw;
                zw += PI_Z;
            end
            for (int i = 0; i < NUM_ITER; i++) begin
                dx = yw >>> i;
                dy = xw >>> i;
                if (zw >= 0) begin
                    xw -= dx; yw += dy; zw -= ATAN_Z[i];
                end else begin
                    xw += dx; yw -= dy; zw += ATAN_Z[i];
                end
            end
            v = limit_to(round_shr(xw * GAIN_INV, 30 + FRAC_SHIFT), -COORD_LIM, COORD_LIM);
            r.x_coord = v[16:0];
            v = limit_to(round_shr(yw * GAIN_INV, 30 + FRAC_SHIFT), -COORD_LIM, COORD_LIM);
            r.y_coord = v[16:0];
        end else begin
            r.form_error = 1'b1;
        end
        return r;
    endfunction

    // Offer one word, with random idle cycles ahead of it, and wait for it
    task automatic send_word(input logic [1:0] cmd, input int a, input int b);
        logic [rpc_pkg::IN_DATA_W-1:0] word;
        word        = '0;
        word[16:0]  = a[16:0];
        word[33:17] = b[16:0];
        while (gap_pct > 0 && $urandom_range(99, 0) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= word;
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(convert_word(cmd, a, b));
    endtask

    // One random word: mostly valid forms, some rejected commands
    task automatic send_random_word();
        int pick, a, b;
        pick = $urandom_range(99, 0);
        if (pick < 45) begin
            if ($urandom_range(3, 0) == 0) begin
                a = int'($urandom_range(64, 0)) - 32;
                b = int'($urandom_range(64, 0)) - 32;
            end else begin
                a = int'($urandom_range(98303, 0)) - 32768;
                b = int'($urandom_range(92160, 0)) - 46080;
            end
            send_word(rpc_pkg::CMD_RECT, a, b);
        end else if (pick < 90) begin
            if ($urandom_range(9, 0) == 0)
                a = int'($urandom_range(98303, 0)) - 32768;
            else
                a = int'($urandom_range(65535, 0));
            b = int'($urandom_range(92160, 0)) - 46080;
            send_word(rpc_pkg::CMD_POLAR, a, b);
        end else begin
            a = int'($urandom_range(98303, 0)) - 32768;
            b = int'($urandom_range(92160, 0)) - 46080;
            send_word((pick < 95) ? CMD_BAD_A : CMD_BAD_B, a, b);
        end
    endtask

    // Corner cases of both forms and the rejected commands
    task automatic test_directed();
        gap_pct   = 0;
        stall_pct = 0;
        send_word(rpc_pkg::CMD_RECT, 0, 0);
        send_word(rpc_pkg::CMD_RECT, 1, 0);
        send_word(rpc_pkg::CMD_RECT, 0, 1);
        send_word(rpc_pkg::CMD_RECT, -1, 0);
        send_word(rpc_pkg::CMD_RECT, -1, -1);
        send_word(rpc_pkg::CMD_RECT, 3, -4);
        send_word(rpc_pkg::CMD_RECT, 65535, 46080);
        send_word(rpc_pkg::CMD_RECT, -32768, -46080);
        send_word(rpc_pkg::CMD_RECT, -32768, 46080);
        send_word(rpc_pkg::CMD_RECT, 65535, 0);
        send_word(rpc_pkg::CMD_RECT, 0, -46080);
        send_word(rpc_pkg::CMD_POLAR, 100, 0);
        send_word(rpc_pkg::CMD_POLAR, 65535, 23040);
        send_word(rpc_pkg::CMD_POLAR, 65535, -23040);
        send_word(rpc_pkg::CMD_POLAR, 65535, 11520);
        send_word(rpc_pkg::CMD_POLAR, 1000, 46080);
        send_word(rpc_pkg::CMD_POLAR, 1000, -46080);
        send_word(rpc_pkg::CMD_POLAR, 65535, 40000);
        send_word(rpc_pkg::CMD_POLAR, -500, 5760);
        send_word(rpc_pkg::CMD_POLAR, -32768, -17280);
        send_word(rpc_pkg::CMD_POLAR, 0, 0);
        send_word(CMD_BAD_A, 65535, -46080);
        send_word(CMD_BAD_B, -32768, 46080);
        send_word(CMD_BAD_A, 0, 0);
    endtask

    task automatic test_random_traffic(input int count, input int send_idle,
                                       input int recv_idle);
        gap_pct   = send_idle;
        stall_pct = recv_idle;
        repeat (count) send_random_word();
    endtask

    // Receiver holds off for a long stretch while words keep coming
    task automatic test_backpressure();
        gap_pct   = 0;
        stall_pct = 0;
        hold_req++;
        repeat (60) send_random_word();
    endtask

    // Receiver: random stalls, or a long hold-off on request
    always @(posedge aclk) begin : receiver
        int hold_left;
        int hold_seen;
        if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= stall_pct);
        end
    end

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    // Result checker: each accepted word against the oldest expectation
    always @(posedge aclk) begin : result_check
        conv_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("result word with no expectation pending");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                compare_field("x_coord",    want.x_coord,    m_tdata[16:0]);
                compare_field("y_coord",    want.y_coord,    m_tdata[33:17]);
                compare_field("magnitude",  want.magnitude,  m_tdata[49:34]);
                compare_field("angle_rad",  want.angle_rad,  m_tdata[65:50]);
                compare_field("form_error", want.form_error, m_tuser[0]);
            end
        end
    end

    // Watchdog on cycles with no word moving on either side
    initial begin : watchdog
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Test sequence
    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= '0;
        s_tdata  <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_traffic(500, 12, 73);
        test_random_traffic(500, 73, 12);
        test_random_traffic(500, 0, 0);
        test_backpressure();
        s_tvalid <= 1'b0;

        // drain, then allow the pipeline latency to pass
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
